### rtl/bmp24_pkg.sv
package bmp24_pkg;

    // Result kinds carried on the master-side tuser.
    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Status codes of a done item.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_SIG = 2'd1;
    localparam logic [1:0] STAT_UNSUPP  = 2'd2;

    // Input commands carried on the slave-side tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Sequencer phases.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;

    // Header constants.
    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BMP_PLANES    = 16'd1;
    localparam logic [15:0] BMP_DEPTH     = 16'd24;

    // Result queue depth; an item is only taken while two entries are free.
    localparam int OQ_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fetch_address;
        logic [23:0] color;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // Writes one byte into a 32-bit little-endian field at the given byte lane.
    function automatic logic [31:0] set_lane(input logic [31:0] word,
                                             input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] w;
        w = word;
        case (lane)
            2'd0:    w[7:0]   = b;
            2'd1:    w[15:8]  = b;
            2'd2:    w[23:16] = b;
            default: w[31:24] = b;
        endcase
        return w;
    endfunction

endpackage

### rtl/bmp24_oq.sv
module bmp24_oq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  bmp24_pkg::res_t     push_res0,
    input  bmp24_pkg::res_t     push_res1,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output bmp24_pkg::res_t     out_res
);
    import bmp24_pkg::*;

    localparam int IW = $clog2(OQ_DEPTH);
    localparam int CW = $clog2(OQ_DEPTH + 1);

    res_t          entry_reg [OQ_DEPTH];
    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [IW-1:0] tail_reg;
    logic [IW-1:0] tail_next;
    logic [IW-1:0] tail_plus1;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          pop;

    assign out_valid  = (count_reg != '0);
    assign out_res    = entry_reg[head_reg];
    assign pop        = out_valid && out_ready;
    // Two free entries cover the worst case of one item.
    assign room       = (count_reg <= CW'(OQ_DEPTH - 2));
    assign tail_plus1 = tail_reg + IW'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + IW'(1) : head_reg;
        tail_next  = tail_reg + IW'(push_cnt);
        count_next = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[tail_reg] <= push_res0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[tail_plus1] <= push_res1;
        end
    end

endmodule

### rtl/bmp24_seq.sv
module bmp24_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic                command,
    input  logic [7:0]          data_byte,
    output logic [1:0]          res_cnt,
    output bmp24_pkg::res_t     res0,
    output bmp24_pkg::res_t     res1
);
    import bmp24_pkg::*;

    // Header byte offsets that steer the parse.
    localparam logic [5:0] OFS_SIG_LO   = 6'd0;
    localparam logic [5:0] OFS_SIG_HI   = 6'd1;
    localparam logic [5:0] OFS_PLN_LO   = 6'd26;
    localparam logic [5:0] OFS_PLN_HI   = 6'd27;
    localparam logic [5:0] OFS_BPP_LO   = 6'd28;
    localparam logic [5:0] OFS_BPP_HI   = 6'd29;
    localparam logic [5:0] OFS_CMP_FIRST = 6'd30;
    localparam logic [5:0] OFS_CMP_LAST  = 6'd33;

    logic [1:0]  phase_reg,     phase_next;
    logic [5:0]  idx_reg,       idx_next;
    logic [15:0] acc_reg,       acc_next;
    logic [31:0] pix_off_reg,   pix_off_next;
    logic [31:0] width_reg,     width_next;
    logic [31:0] height_reg,    height_next;
    logic [31:0] h_abs_reg,     h_abs_next;
    logic        bottom_up_reg, bottom_up_next;
    logic        sizes_ok_reg,  sizes_ok_next;
    logic [31:0] start_line_reg, start_line_next;
    logic [31:0] pitch_reg,     pitch_next;
    logic [31:0] step_reg,      step_next;
    logic [31:0] prod_reg,      prod_next;
    logic [31:0] row_base_reg,  row_base_next;
    logic [31:0] row_cnt_reg,   row_cnt_next;
    logic [31:0] col_cnt_reg,   col_cnt_next;
    logic [1:0]  bop_reg,       bop_next;
    logic [31:0] addr_reg,      addr_next;

    logic [1:0]  lane;
    logic [15:0] field16;
    logic [31:0] h_neg;
    logic [31:0] col_inc;
    logic [31:0] row_inc;
    logic [31:0] base_stepped;
    res_t        fetch_r;
    res_t        done_r;

    assign lane    = 2'(idx_reg - 6'd2);
    assign field16 = {data_byte, acc_reg[7:0]};
    assign h_neg   = 32'd0 - height_reg;
    assign col_inc = col_cnt_reg + 32'd1;
    assign row_inc = row_cnt_reg + 32'd1;
    assign base_stepped = row_base_reg + step_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        pix_off_next    = pix_off_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        h_abs_next      = h_abs_reg;
        bottom_up_next  = bottom_up_reg;
        sizes_ok_next   = sizes_ok_reg;
        start_line_next = start_line_reg;
        pitch_next      = pitch_reg;
        step_next       = step_reg;
        prod_next       = prod_reg;
        row_base_next   = row_base_reg;
        row_cnt_next    = row_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        bop_next        = bop_reg;
        addr_next       = addr_reg;
        res_cnt         = 2'd0;
        fetch_r         = '0;
        fetch_r.kind    = KIND_FETCH;
        fetch_r.last    = 1'b1;
        done_r          = '0;
        done_r.kind     = KIND_DONE;
        done_r.last     = 1'b1;
        res0            = fetch_r;
        res1            = fetch_r;

        if (go && command == CMD_START)
        begin
            phase_next   = PH_HEADER;
            idx_next     = '0;
            pix_off_next = '0;
            width_next   = '0;
            height_next  = '0;
            addr_next    = '0;
            res_cnt      = 2'd1;
        end
        else if (go)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    // Every header byte requests the next offset unless the
                    // byte closes the header or fails a check.
                    idx_next = idx_reg + 6'd1;
                    res0.fetch_address = {26'd0, idx_next};
                    res_cnt = 2'd1;
                    if (idx_reg >= 6'd10 && idx_reg <= 6'd13)
                        pix_off_next = set_lane(pix_off_reg, lane, data_byte);
                    if (idx_reg >= 6'd18 && idx_reg <= 6'd21)
                        width_next = set_lane(width_reg, lane, data_byte);
                    if (idx_reg >= 6'd22 && idx_reg <= 6'd25)
                        height_next = set_lane(height_reg, lane, data_byte);
                    if (idx_reg == OFS_SIG_LO || idx_reg == OFS_PLN_LO ||
                        idx_reg == OFS_BPP_LO || idx_reg == OFS_CMP_FIRST)
                        acc_next = {8'd0, data_byte};
                    if (idx_reg > OFS_CMP_FIRST)
                        acc_next = acc_reg | {8'd0, data_byte};

                    // Geometry is spread over the plane and depth bytes so
                    // that the multiply and the row-base add do not share a byte.
                    if (idx_reg == OFS_PLN_LO)
                    begin
                        bottom_up_next  = !height_reg[31];
                        h_abs_next      = height_reg[31] ? h_neg : height_reg;
                        start_line_next = height_reg[31] ? 32'd0
                                                         : height_reg - 32'd1;
                        pitch_next = (width_reg + {width_reg[30:0], 1'b0} + 32'd3)
                                     & ~32'd3;
                    end
                    if (idx_reg == OFS_PLN_HI)
                    begin
                        prod_next     = start_line_reg * pitch_reg;
                        step_next     = bottom_up_reg ? 32'd0 - pitch_reg : pitch_reg;
                        sizes_ok_next = width_reg != 32'd0 && !width_reg[31] &&
                                        h_abs_reg != 32'd0 && !h_abs_reg[31];
                    end
                    if (idx_reg == OFS_BPP_LO)
                        row_base_next = pix_off_reg + prod_reg;

                    if (idx_reg == OFS_SIG_HI && field16 != BMP_SIGNATURE)
                    begin
                        phase_next = PH_IDLE;
                        res0       = done_r;
                        res0.status = STAT_BAD_SIG;
                    end
                    else if ((idx_reg == OFS_PLN_HI && field16 != BMP_PLANES) ||
                             (idx_reg == OFS_BPP_HI && field16 != BMP_DEPTH))
                    begin
                        phase_next  = PH_IDLE;
                        res0        = done_r;
                        res0.status = STAT_UNSUPP;
                    end
                    else if (idx_reg == OFS_CMP_LAST)
                    begin
                        if ((acc_reg[7:0] | data_byte) != 8'd0)
                        begin
                            phase_next  = PH_IDLE;
                            res0        = done_r;
                            res0.status = STAT_UNSUPP;
                        end
                        else if (!sizes_ok_reg)
                        begin
                            phase_next  = PH_IDLE;
                            res0        = done_r;
                            res0.status = STAT_OK;
                        end
                        else
                        begin
                            phase_next   = PH_PIXELS;
                            row_cnt_next = '0;
                            col_cnt_next = '0;
                            bop_next     = '0;
                            addr_next    = row_base_reg;
                            res0.fetch_address = row_base_reg;
                        end
                    end
                end

                PH_PIXELS:
                begin
                    case (bop_reg)
                        2'd0, 2'd1:
                        begin
                            if (bop_reg == 2'd0)
                                acc_next = {8'd0, data_byte};
                            else
                                acc_next = field16;
                            bop_next  = bop_reg + 2'd1;
                            addr_next = addr_reg + 32'd1;
                            res0.fetch_address = addr_next;
                            res_cnt   = 2'd1;
                        end
                        default:
                        begin
                            bop_next   = '0;
                            res0       = '0;
                            res0.kind  = KIND_PIXEL;
                            res0.color = {data_byte, acc_reg};
                            res_cnt    = 2'd2;
                            if (col_inc == width_reg)
                            begin
                                col_cnt_next = '0;
                                row_cnt_next = row_inc;
                                if (row_inc == h_abs_reg)
                                begin
                                    phase_next = PH_IDLE;
                                    res1       = done_r;
                                end
                                else
                                begin
                                    row_base_next = base_stepped;
                                    addr_next     = base_stepped;
                                    res1.fetch_address = base_stepped;
                                end
                            end
                            else
                            begin
                                col_cnt_next = col_inc;
                                addr_next    = addr_reg + 32'd1;
                                res1.fetch_address = addr_next;
                            end
                        end
                    endcase
                end

                default:
                begin
                    res_cnt = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            bop_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            bop_reg   <= bop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        pix_off_reg    <= pix_off_next;
        width_reg      <= width_next;
        height_reg     <= height_next;
        h_abs_reg      <= h_abs_next;
        bottom_up_reg  <= bottom_up_next;
        sizes_ok_reg   <= sizes_ok_next;
        start_line_reg <= start_line_next;
        pitch_reg      <= pitch_next;
        step_reg       <= step_next;
        prod_reg       <= prod_next;
        row_base_reg   <= row_base_next;
        row_cnt_reg    <= row_cnt_next;
        col_cnt_reg    <= col_cnt_next;
        addr_reg       <= addr_next;
    end

endmodule

### rtl/bmp24_reader_address_sequencer_core.sv
// Channel   Direction  tuser            tdata (low bit up)                      tlast
// s_axis    in         command          data_byte                               -
// m_axis    out        kind             fetch_address, color, status, pad       last
//
// An accepted transfer is held in the input register, is handled once the
// result queue has room, and its results are registered in that queue.
// The block takes one transfer per cycle while the queue has room; it only
// takes an item while two of the four queue entries are free, as an item
// that ends a pixel gives two results.
// Reset is asynchronous and active low; it idles the sequencer and empties
// the input register and the result queue. A stall on m_axis fills the queue
// and then holds s_axis_tready low until entries drain.
module bmp24_reader_address_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // fetch_address[31:0], color[55:32],
                                        // status[57:56], zero[63:58]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast    // last
);
    import bmp24_pkg::*;

    // Input register: holds one transfer until the sequencer can take it.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       consume;
    logic       take;

    logic [1:0] res_cnt;
    res_t       res0;
    res_t       res1;
    res_t       out_res;

    // The sequencer consumes the held item whenever the queue has space for
    // its worst case, so a new transfer can land in the same cycle.
    assign consume       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || consume;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    bmp24_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (consume),
        .command   (in_cmd_reg),
        .data_byte (in_byte_reg),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    bmp24_oq u_oq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (res_cnt),
        .push_res0 (res0),
        .push_res1 (res1),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.status, out_res.color, out_res.fetch_address};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

// Stream-level check of the 24-bit BMP reader address sequencer.
// The initial block builds byte streams shaped like BMP files (well-formed
// images with random pixel content, broken headers, empty images, aborted
// images) and noise streams, and queues them for the driver. A bit-accurate
// model of the sequencer runs on every accepted transfer and queues the fetch,
// pixel and done results it should produce. The monitor compares each
// result transfer field by field against the oldest queued result.
module testbench;

    import bmp24_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;

    // Kinds of byte streams the stimulus generator can produce.
    typedef enum int {
        IMG_GOOD,
        IMG_WRAP,
        IMG_ABORT_PIXELS,
        IMG_ABORT_HEADER,
        IMG_BAD_SIG,
        IMG_BAD_PLANES,
        IMG_BAD_DEPTH,
        IMG_BAD_COMPR,
        IMG_EMPTY,
        IMG_NOISE,
        IMG_KIND_COUNT
    } image_kind_e;

    // Patterns the result side switches between at random when it is not held off.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_pattern_e;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } file_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tuser = CMD_DATA;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    bmp24_reader_address_sequencer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transfers waiting to be offered, and results the sequencer owes us.
    file_item_t  byte_stream[$];
    res_t        reader_results[$];
    logic [7:0]  header_bytes[$];

    int items_offered = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int hold_requests = 0;

    // Shadow copy of the sequencer state.
    logic [1:0]  rd_phase;
    logic [5:0]  hdr_index;
    logic [31:0] field_bit;
    logic [31:0] data_offset;
    logic [31:0] img_width;
    logic [31:0] img_height;
    logic        rows_bottom_up;
    logic [31:0] row_pitch;
    logic [31:0] rows_done;
    logic [31:0] cols_done;
    logic [1:0]  pixel_lane;
    logic [15:0] assembled;
    logic [31:0] fetch_ptr;

    task automatic clear_reader();
        rd_phase       = PH_IDLE;
        hdr_index      = 6'd0;
        field_bit      = 32'd0;
        data_offset    = 32'd0;
        img_width      = 32'd0;
        img_height     = 32'd0;
        rows_bottom_up = 1'b1;
        row_pitch      = 32'd0;
        rows_done      = 32'd0;
        cols_done      = 32'd0;
        pixel_lane     = 2'd0;
        assembled      = 16'd0;
        fetch_ptr      = 32'd0;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [31:0] address,
                               input logic [23:0] color, input logic [1:0] status,
                               input logic last);
        res_t r;
        r.kind          = kind;
        r.fetch_address = address;
        r.color         = color;
        r.status        = status;
        r.last          = last;
        reader_results.push_back(r);
    endtask

    task automatic close_image(input logic [1:0] status);
        rd_phase = PH_IDLE;
        push_result(KIND_DONE, 32'd0, 24'd0, status, 1'b1);
    endtask

    // Header offsets where a new little-endian field begins.
    function automatic logic starts_field(input logic [5:0] idx);
        return idx inside {6'd0, 6'd2, 6'd6, 6'd10, 6'd14, 6'd18, 6'd22, 6'd26,
                           6'd28, 6'd30};
    endfunction

    function automatic logic [31:0] line_address(input logic [31:0] row);
        logic [31:0] line;
        line = rows_bottom_up ? img_height - 32'd1 - row : row;
        return data_offset + line * row_pitch;
    endfunction

    // Advances the shadow sequencer by one accepted transfer and queues the
    // results that transfer must produce.
    task automatic advance_reader(input logic command, input logic [7:0] b);
        logic [5:0]  idx;
        logic [4:0]  sh;
        logic [31:0] wide;
        logic [23:0] pixel;
        if (command == CMD_START)
        begin
            clear_reader();
            rd_phase = PH_HEADER;
            push_result(KIND_FETCH, 32'd0, 24'd0, STAT_OK, 1'b1);
        end
        else if (rd_phase == PH_HEADER)
        begin
            idx = hdr_index;
            if (starts_field(idx))
                field_bit = 32'd0;
            sh = field_bit[4:0];
            if (idx <= 1 || (idx >= 26 && idx <= 29))
            begin
                // Signature, planes and depth are assembled as 16-bit values.
                if (starts_field(idx))
                    assembled = 16'd0;
                wide = {16'd0, assembled} | ({24'd0, b} << sh);
                assembled = wide[15:0];
            end
            else if (idx >= 30 && idx <= 33)
            begin
                // Compression only has to be zero, so its bytes are ORed.
                if (idx == 30)
                    assembled = 16'd0;
                assembled = assembled | {8'd0, b};
            end
            else if (idx >= 10 && idx <= 13)
                data_offset = data_offset | ({24'd0, b} << sh);
            else if (idx >= 18 && idx <= 21)
                img_width = img_width | ({24'd0, b} << sh);
            else if (idx >= 22 && idx <= 25)
                img_height = img_height | ({24'd0, b} << sh);
            field_bit = field_bit + 32'd8;

            if (idx == 1 && assembled != BMP_SIGNATURE)
                close_image(STAT_BAD_SIG);
            else if (idx == 27 && assembled != BMP_PLANES)
                close_image(STAT_UNSUPP);
            else if (idx == 29 && assembled != BMP_DEPTH)
                close_image(STAT_UNSUPP);
            else if (idx == 33)
            begin
                if (assembled != 16'd0)
                    close_image(STAT_UNSUPP);
                else
                begin
                    row_pitch = (img_width * 32'd3 + 32'd3) & ~32'd3;
                    if (img_height[31])
                    begin
                        img_height     = 32'd0 - img_height;
                        rows_bottom_up = 1'b0;
                    end
                    assembled = 16'd0;
                    // A height of -2^31 stays negative and counts as empty.
                    if (img_width == 32'd0 || img_width[31] ||
                        img_height == 32'd0 || img_height[31])
                        close_image(STAT_OK);
                    else
                    begin
                        rd_phase   = PH_PIXELS;
                        rows_done  = 32'd0;
                        cols_done  = 32'd0;
                        pixel_lane = 2'd0;
                        fetch_ptr  = line_address(32'd0);
                        push_result(KIND_FETCH, fetch_ptr, 24'd0, STAT_OK, 1'b1);
                    end
                end
            end
            else
            begin
                hdr_index = idx + 6'd1;
                fetch_ptr = {26'd0, hdr_index};
                push_result(KIND_FETCH, fetch_ptr, 24'd0, STAT_OK, 1'b1);
            end
        end
        else if (rd_phase == PH_PIXELS)
        begin
            if (pixel_lane < 2)
            begin
                // Blue then green are held until red arrives.
                assembled  = assembled | ({8'd0, b} << (8 * pixel_lane));
                pixel_lane = pixel_lane + 2'd1;
                fetch_ptr  = fetch_ptr + 32'd1;
                push_result(KIND_FETCH, fetch_ptr, 24'd0, STAT_OK, 1'b1);
            end
            else
            begin
                pixel      = {b, assembled};
                assembled  = 16'd0;
                pixel_lane = 2'd0;
                push_result(KIND_PIXEL, 32'd0, pixel, STAT_OK, 1'b0);
                cols_done = cols_done + 32'd1;
                if (cols_done == img_width)
                begin
                    cols_done = 32'd0;
                    rows_done = rows_done + 32'd1;
                    if (rows_done == img_height)
                        close_image(STAT_OK);
                    else
                        fetch_ptr = line_address(rows_done);
                end
                else
                    fetch_ptr = fetch_ptr + 32'd1;
                // The last pixel of an image is followed by done, not a fetch.
                if (rd_phase == PH_PIXELS)
                    push_result(KIND_FETCH, fetch_ptr, 24'd0, STAT_OK, 1'b1);
            end
        end
        // Data while idle is dropped by the block without any result.
    endtask

    task automatic push_item(input logic command, input logic [7:0] value,
                             input bit counts);
        file_item_t it;
        it.command   = command;
        it.data_byte = value;
        byte_stream.push_back(it);
        if (counts)
            items_offered++;
    endtask

    task automatic push_le(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            header_bytes.push_back(value[8 * i +: 8]);
    endtask

    // Queues one start transfer followed by the bytes of one file, or a run of noise transfers.
    task automatic queue_image(input image_kind_e kind);
        logic [15:0] sig;
        logic [15:0] planes;
        logic [15:0] depth;
        logic [31:0] compr;
        logic [31:0] offset;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] magnitude;
        int header_len;
        int pixel_bytes;
        int trailing;
        int noise_len;

        sig    = BMP_SIGNATURE;
        planes = BMP_PLANES;
        depth  = BMP_DEPTH;
        compr  = 32'd0;
        offset = $urandom_range(54, 4096);
        width  = $urandom_range(1, 5);
        height = $urandom_range(1, 4);
        if ($urandom_range(0, 9) < 4)
            height = -height;
        header_len  = 34;
        pixel_bytes = 0;
        trailing    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;

        case (kind)
            IMG_GOOD: ;
            IMG_WRAP:
                offset = 32'hFFFF_FFFF - $urandom_range(0, 40);
            IMG_ABORT_PIXELS:
            begin
                // Huge images: row addresses wrap, and the next start cuts them short.
                offset = $urandom();
                width  = $urandom_range(20, 32'h7FFF_FFFF);
                height = $urandom_range(1, 32'h7FFF_FFFF);
                if ($urandom_range(0, 1) == 1)
                    height = -height;
                pixel_bytes = $urandom_range(1, 45);
                trailing    = 0;
            end
            IMG_ABORT_HEADER:
            begin
                header_len = $urandom_range(0, 33);
                trailing   = 0;
            end
            IMG_BAD_SIG:
            begin
                sig        = BMP_SIGNATURE ^ 16'($urandom_range(1, 16'hFFFF));
                header_len = 2;
            end
            IMG_BAD_PLANES:
            begin
                planes     = BMP_PLANES ^ 16'($urandom_range(1, 16'hFFFF));
                header_len = 28;
            end
            IMG_BAD_DEPTH:
            begin
                // Half the time only the upper byte is off, so 24 still sits below.
                if ($urandom_range(0, 1) == 1)
                    depth = BMP_DEPTH ^ (16'($urandom_range(1, 255)) << 8);
                else
                    depth = BMP_DEPTH ^ 16'($urandom_range(1, 16'hFFFF));
                header_len = 30;
            end
            IMG_BAD_COMPR:
                compr = 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
            IMG_EMPTY:
            begin
                case ($urandom_range(0, 3))
                    0:       width  = 32'd0;
                    1:       width  = 32'h8000_0000 | $urandom();
                    2:       height = 32'd0;
                    default: height = 32'h8000_0000;
                endcase
            end
            default:
            begin
                // Noise: random starts and bytes, mostly bytes.
                noise_len = $urandom_range(4, 16);
                for (int i = 0; i < noise_len; i++)
                    push_item(($urandom_range(0, 4) == 0) ? CMD_START : CMD_DATA,
                              8'($urandom_range(0, 255)), 1'b1);
                return;
            end
        endcase

        if (kind == IMG_GOOD || kind == IMG_WRAP)
        begin
            magnitude   = height[31] ? -height : height;
            pixel_bytes = 3 * int'(width) * int'(magnitude);
        end

        header_bytes.delete();
        push_le({16'd0, sig}, 2);
        push_le($urandom(), 4);
        push_le($urandom(), 4);
        push_le(offset, 4);
        push_le($urandom(), 4);
        push_le(width, 4);
        push_le(height, 4);
        push_le({16'd0, planes}, 2);
        push_le({16'd0, depth}, 2);
        push_le(compr, 4);

        push_item(CMD_START, 8'($urandom_range(0, 255)), 1'b1);
        for (int i = 0; i < header_len; i++)
            push_item(CMD_DATA, header_bytes[i], 1'b1);
        for (int i = 0; i < pixel_bytes; i++)
            push_item(CMD_DATA, 8'($urandom_range(0, 255)), 1'b1);
        // Bytes after a done item land on an idle block and must be ignored.
        for (int i = 0; i < trailing; i++)
            push_item(CMD_DATA, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Waits until every queued transfer is taken and every result has come.
    task automatic wait_until_quiet();
        while (byte_stream.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (reader_results.size() != 0)
            @(posedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps. The model is
    // advanced at the edge where a transfer is accepted.
    file_item_t next_item;
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_reader(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0 || byte_stream.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    next_item = byte_stream.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_item.command;
                    s_axis_tdata  <= next_item.data_byte;
                    if (burst_left != 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                : $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: switches between ready patterns, and honors requests for a
    // long hold-off that it counts out itself.
    rx_pattern_e rx_pattern = RX_ALWAYS;
    int pattern_left = 0;
    int hold_left    = 0;
    int holds_served = 0;
    int rx_phase     = 0;

    always @(posedge clk)
    begin
        rx_phase++;
        if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                rx_pattern   = rx_pattern_e'($urandom_range(0, 3));
                pattern_left = $urandom_range(10, 80);
            end
            else
                pattern_left--;
            case (rx_pattern)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ((rx_phase % 5) < 3);
            endcase
        end
    end

    // Monitor: every result transfer is matched against the oldest queued one.
    res_t wanted;
    res_t seen;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.kind          = m_axis_tuser;
            seen.fetch_address = m_axis_tdata[31:0];
            seen.color         = m_axis_tdata[55:32];
            seen.status        = m_axis_tdata[57:56];
            seen.last          = m_axis_tlast;
            if (reader_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with none expected: kind %0d addr %h color %h",
                         $time, seen.kind, seen.fetch_address, seen.color);
            end
            else
            begin
                wanted = reader_results.pop_front();
                // Padding bits above status must read as zero.
                if (seen !== wanted || m_axis_tdata[63:58] !== 6'd0)
                begin
                    mismatches++;
                    // Keep the log bounded if the design is badly off.
                    if (mismatches <= 200)
                    begin
                        $display("%0t ns: expected kind %0d addr %h color %h status %0d last %b",
                                 $time, wanted.kind, wanted.fetch_address, wanted.color,
                                 wanted.status, wanted.last);
                        $display("%0t ns: actual kind %0d addr %h color %h status %0d last %b pad %h",
                                 $time, seen.kind, seen.fetch_address, seen.color,
                                 seen.status, seen.last, m_axis_tdata[63:58]);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    image_kind_e kind;
    int images = 0;

    initial
    begin
        clear_reader();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bytes on an idle block, a start that aborts a header, and
        // signature failures on either byte, with data at both extremes.
        push_item(CMD_DATA, 8'h00, 1'b0);
        push_item(CMD_DATA, 8'hFF, 1'b0);
        push_item(CMD_START, 8'hFF, 1'b1);
        push_item(CMD_DATA, 8'h42, 1'b1);
        push_item(CMD_DATA, 8'h4D, 1'b1);
        push_item(CMD_DATA, 8'h00, 1'b1);
        push_item(CMD_DATA, 8'hFF, 1'b1);
        push_item(CMD_START, 8'h00, 1'b1);
        push_item(CMD_DATA, 8'h00, 1'b1);
        push_item(CMD_DATA, 8'h4D, 1'b1);
        push_item(CMD_DATA, 8'hAA, 1'b0);
        push_item(CMD_START, 8'h5A, 1'b1);
        push_item(CMD_DATA, 8'h42, 1'b1);
        push_item(CMD_DATA, 8'h00, 1'b1);
        push_item(CMD_START, 8'h00, 1'b1);
        push_item(CMD_DATA, 8'hFF, 1'b1);
        push_item(CMD_DATA, 8'hFF, 1'b1);
        wait_until_quiet();

        // The result side stalls for a long stretch while full images keep
        // coming, so the result queue fills and input transfers back up.
        hold_requests++;
        queue_image(IMG_GOOD);
        queue_image(IMG_GOOD);

        // Every kind once in order, then a weighted mix, pausing now and then
        // until the block has gone quiet.
        while (items_offered < ITEM_TARGET)
        begin
            if (images < IMG_KIND_COUNT)
                kind = image_kind_e'(images);
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:44]:  kind = IMG_GOOD;
                    [45:52]: kind = IMG_WRAP;
                    [53:60]: kind = IMG_ABORT_PIXELS;
                    [61:66]: kind = IMG_ABORT_HEADER;
                    [67:72]: kind = IMG_BAD_SIG;
                    [73:77]: kind = IMG_BAD_PLANES;
                    [78:82]: kind = IMG_BAD_DEPTH;
                    [83:87]: kind = IMG_BAD_COMPR;
                    [88:94]: kind = IMG_EMPTY;
                    default: kind = IMG_NOISE;
                endcase
            end
            queue_image(kind);
            images++;
            if (images % 12 == 0)
                wait_until_quiet();
        end

        wait_until_quiet();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
